// ===== src/rhc_pkg.sv =====
`default_nettype none
package rhc_pkg;

  // Number of quotient bits, one divider cell per bit.
  localparam int QW = 8;
  // Width of the partial remainders in the divider chain.
  localparam int RW = 16;

  localparam logic [7:0] GREY_HUE   = 8'd160;
  localparam logic [7:0] HUE_GREEN  = 8'd80;
  localparam logic [7:0] HUE_BLUE   = 8'd160;
  localparam logic [7:0] LUM_LOW    = 8'd120;
  localparam logic [7:0] CH_MAX     = 8'd255;

  // Level selection for one output channel of the HSL to RGB path.
  typedef enum logic [1:0] {
    SEL_RAMP = 2'd0,
    SEL_HI   = 2'd1,
    SEL_LO   = 2'd2
  } sel_t;

  // One item as it travels down the divider chain.
  typedef struct packed {
    logic            kind;
    // RGB to HSL side.
    logic            grey;
    logic [7:0]      lum;
    logic [7:0]      hbase;
    logic            hneg;
    logic [RW-1:0]   srem;
    logic [7:0]      sden;
    logic [QW-1:0]   sq;
    logic [RW-1:0]   hrem;
    logic [7:0]      hden;
    logic [QW-1:0]   hq;
    // HSL to RGB side.
    logic            szero;
    logic            lowl;
    logic [7:0]      lin;
    logic [7:0]      sin;
    logic [15:0]     prod;
    logic [2:0][5:0] fac;
    sel_t [2:0]      sel;
  } item_t;

  // Floor of x / 240 for any 16-bit x: (x >> 4) / 15 by reciprocal.
  function automatic logic [8:0] div240(input logic [15:0] x);
    logic [24:0] p;
    p = 25'(x[15:4]) * 25'd4370;
    return p[24:16];
  endfunction

  // Floor of x / 40 for x below 40960: (x >> 3) / 5 by reciprocal.
  function automatic logic [9:0] div40(input logic [15:0] x);
    logic [26:0] p;
    p = 27'(x[15:3]) * 27'd13108;
    return p[25:16];
  endfunction

endpackage
`default_nettype wire

// ===== src/rhc_if.sv =====
`default_nettype none
// Input channel: one colour and the conversion direction.
interface rhc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] hue_in;
  logic [7:0] sat_in;
  logic [7:0] lum_in;

  modport source (output valid, kind, red_in, green_in, blue_in, hue_in, sat_in, lum_in,
                  input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, hue_in, sat_in, lum_in,
                output ready);
endinterface

// Output channel: the converted colour.
interface rhc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] hue_out;
  logic [7:0] sat_out;
  logic [7:0] lum_out;

  modport source (output valid, red_out, green_out, blue_out, hue_out, sat_out, lum_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, hue_out, sat_out, lum_out,
                output ready);
endinterface
`default_nettype wire

// ===== src/rhc_front.sv =====
`default_nettype none
module rhc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  rhc_in_if.sink             req,
  output rhc_pkg::item_t     item,
  output logic               vld
);
  import rhc_pkg::*;

  item_t              item_next;
  logic [7:0]         r, g, b, mx, mn, diff;
  logic [8:0]         sum;
  logic [16:0]        lnum;
  logic [32:0]        lprod;
  logic signed [15:0] delta, hn;
  logic [8:0]         m9;
  logic [16:0]        prod17;
  logic [2:0][8:0]    idx;

  // No transfer is taken while reset is high.
  assign req.ready = en && !rst;
  assign r = req.red_in;
  assign g = req.green_in;
  assign b = req.blue_in;

  // Operand setup for both directions.
  always_comb begin
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    sum = 9'(mx) + 9'(mn);
    diff = mx - mn;

    item_next = '0;
    item_next.kind = req.kind;
    item_next.grey = (diff == 8'd0);

    // Luminosity: (sum*240 + 255) / 510 as ((..) >> 1) / 255.
    lnum = 17'(sum) * 17'd240 + 17'd255;
    lprod = 33'(lnum[16:1]) * 33'd65794;
    item_next.lum = lprod[31:24];

    // Saturation dividend and divisor.
    item_next.sden = (sum <= 9'(CH_MAX)) ? sum[7:0] : 8'(10'd510 - 10'(sum));
    item_next.srem = 16'(diff) * 16'd240 + 16'(item_next.sden[7:1]);

    // Hue: pick the largest channel, red first, then green.
    if (mx == r) begin
      delta = $signed({8'b0, g}) - $signed({8'b0, b});
      item_next.hbase = 8'd0;
    end else if (mx == g) begin
      delta = $signed({8'b0, b}) - $signed({8'b0, r});
      item_next.hbase = HUE_GREEN;
    end else begin
      delta = $signed({8'b0, r}) - $signed({8'b0, g});
      item_next.hbase = HUE_BLUE;
    end
    hn = delta * 16'sd40 + $signed({9'b0, diff[7:1]});
    item_next.hneg = hn[15];
    item_next.hrem = hn[15] ? 16'(-hn) : 16'(hn);
    item_next.hden = diff;

    // HSL side: product for the upper level n2.
    item_next.lin = req.lum_in;
    item_next.sin = req.sat_in;
    item_next.szero = (req.sat_in == 8'd0);
    item_next.lowl = (req.lum_in <= LUM_LOW);
    m9 = item_next.lowl ? (9'(req.sat_in) + 9'd240) : 9'(req.sat_in);
    prod17 = 17'(req.lum_in) * 17'(m9) + 17'd120;
    item_next.prod = prod17[15:0];

    // Hue positions for red, green and blue, wrapped into 0..240.
    idx[0] = 9'(req.hue_in) + 9'd80;
    if (idx[0] > 9'd240) idx[0] = idx[0] - 9'd240;
    idx[1] = (req.hue_in > 8'd240) ? 9'(req.hue_in) - 9'd240 : 9'(req.hue_in);
    idx[2] = (req.hue_in < 8'd80) ? 9'(req.hue_in) + 9'd160 : 9'(req.hue_in) - 9'd80;
    for (int c = 0; c < 3; c++) begin
      if (idx[c] < 9'd40) begin
        item_next.sel[c] = SEL_RAMP;
        item_next.fac[c] = idx[c][5:0];
      end else if (idx[c] < 9'd120) begin
        item_next.sel[c] = SEL_HI;
        item_next.fac[c] = 6'd0;
      end else if (idx[c] < 9'd160) begin
        item_next.sel[c] = SEL_RAMP;
        item_next.fac[c] = 6'(9'd160 - idx[c]);
      end else begin
        item_next.sel[c] = SEL_LO;
        item_next.fac[c] = 6'd0;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/rhc_div_cell.sv =====
`default_nettype none
module rhc_div_cell #(
  parameter int BIT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire rhc_pkg::item_t din,
  input  wire logic           din_vld,
  output rhc_pkg::item_t      dout,
  output logic                dout_vld
);
  import rhc_pkg::*;

  item_t       item_next;
  logic [16:0] s_sh, h_sh;

  // One restoring step for the saturation and hue quotients.
  always_comb begin
    item_next = din;
    s_sh = 17'(din.sden) << BIT;
    h_sh = 17'(din.hden) << BIT;
    if ({1'b0, din.srem} >= s_sh) begin
      item_next.srem = din.srem - s_sh[15:0];
      item_next.sq[BIT] = 1'b1;
    end
    if ({1'b0, din.hrem} >= h_sh) begin
      item_next.hrem = din.hrem - h_sh[15:0];
      item_next.hq[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_vld <= 1'b0;
    end else if (en) begin
      dout_vld <= din_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/rhc_back.sv =====
`default_nettype none
module rhc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire rhc_pkg::item_t din,
  input  wire logic           din_vld,
  rhc_out_if.source           rsp
);
  import rhc_pkg::*;

  // Results of the RGB to HSL side, carried to the output.
  typedef struct packed {
    logic       kind;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] lum;
  } hsl_t;

  typedef struct packed {
    hsl_t             hsl;
    logic             szero;
    logic [7:0]       lin;
    logic [9:0]       hi;
    logic signed [10:0] lo;
    logic [2:0][5:0]  fac;
    sel_t [2:0]       sel;
  } st1_t;

  typedef struct packed {
    hsl_t                     hsl;
    logic                     szero;
    logic [7:0]               lin;
    logic [9:0]               hi;
    logic signed [10:0]       lo;
    logic [2:0][16:0]         num;
    sel_t [2:0]               sel;
  } st2_t;

  typedef struct packed {
    hsl_t             hsl;
    logic [2:0][11:0] lvl;
  } st3_t;

  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  logic v1, v2, v3, v4;

  logic signed [8:0]  hs;
  logic signed [9:0]  hsum;
  logic [8:0]         q240;
  logic signed [10:0] d;
  logic signed [16:0] n;
  logic [15:0]        mag;
  logic [9:0]         q40;
  logic signed [11:0] qs, v;
  logic signed [19:0] cnum;
  logic [8:0]         cq;
  logic [2:0][7:0]    ch;

  // Stage 1: finish hue and saturation, upper and lower levels.
  always_comb begin
    s1_next = '0;
    s1_next.hsl.kind = din.kind;
    hs = din.hneg ? -$signed({1'b0, din.hq}) : $signed({1'b0, din.hq});
    hsum = $signed({2'b0, din.hbase}) + {hs[8], hs};
    if (hsum < 0) hsum = hsum + 10'sd240;
    s1_next.hsl.hue = din.grey ? GREY_HUE : hsum[7:0];
    s1_next.hsl.sat = din.grey ? 8'd0 : din.sq;
    s1_next.hsl.lum = din.lum;
    q240 = div240(din.prod);
    s1_next.hi = din.lowl ? 10'(q240) : (10'(din.lin) + 10'(din.sin) - 10'(q240));
    s1_next.lo = $signed({2'b0, din.lin, 1'b0}) - $signed({1'b0, s1_next.hi});
    s1_next.szero = din.szero;
    s1_next.lin = din.lin;
    s1_next.fac = din.fac;
    s1_next.sel = din.sel;
  end

  // Stage 2: ramp dividends (hi - lo) * f + 20.
  always_comb begin
    s2_next.hsl = s1.hsl;
    s2_next.szero = s1.szero;
    s2_next.lin = s1.lin;
    s2_next.hi = s1.hi;
    s2_next.lo = s1.lo;
    s2_next.sel = s1.sel;
    d = $signed({1'b0, s1.hi}) - s1.lo;
    for (int c = 0; c < 3; c++) begin
      s2_next.num[c] = 17'(17'(d) * $signed({11'b0, s1.fac[c]}) + 17'sd20);
    end
  end

  // Stage 3: divide by 40 toward zero and pick each channel level.
  always_comb begin
    s3_next.hsl = s2.hsl;
    for (int c = 0; c < 3; c++) begin
      n = $signed(s2.num[c]);
      mag = n[16] ? 16'(-n) : n[15:0];
      q40 = div40(mag);
      qs = n[16] ? -$signed({2'b0, q40}) : $signed({2'b0, q40});
      case (s2.sel[c])
        SEL_RAMP: v = 12'(s2.lo) + qs;
        SEL_HI:   v = $signed({2'b0, s2.hi});
        SEL_LO:   v = 12'(s2.lo);
        default:  v = 12'(s2.lo);
      endcase
      if (s2.szero) v = $signed({4'b0, s2.lin});
      s3_next.lvl[c] = v;
    end
  end

  // Stage 4: scale to 0..255 with clamping at both ends.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cnum = 20'($signed(s3.lvl[c])) * 20'sd255 + 20'sd120;
      cq = div240(cnum[15:0]);
      if (cnum <= 0) begin
        ch[c] = 8'd0;
      end else if (cnum >= 20'sd61440) begin
        ch[c] = CH_MAX;
      end else begin
        ch[c] = cq[7:0];
      end
    end
  end

  // Valid bits of the back stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= din_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage data and the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      if (s3.hsl.kind) begin
        rsp.red_out   <= ch[0];
        rsp.green_out <= ch[1];
        rsp.blue_out  <= ch[2];
        rsp.hue_out   <= 8'd0;
        rsp.sat_out   <= 8'd0;
        rsp.lum_out   <= 8'd0;
      end else begin
        rsp.red_out   <= 8'd0;
        rsp.green_out <= 8'd0;
        rsp.blue_out  <= 8'd0;
        rsp.hue_out   <= s3.hsl.hue;
        rsp.sat_out   <= s3.hsl.sat;
        rsp.lum_out   <= s3.hsl.lum;
      end
    end
  end

  assign rsp.valid = v4;

endmodule
`default_nettype wire

// ===== src/rgb_hsl_240_converter_top.sv =====
`default_nettype none
// RGB <-> HSL (0..240 scale) converter. Each transfer on req carries a colour and a
// direction bit; each produces exactly one transfer on rsp, in order. The block takes
// one item per clock when rsp is ready. The pipeline is made of one setup stage,
// a chain of eight divider cells that each resolve one quotient bit of the saturation
// and hue divisions, three stages for the level selection, and the output register,
// which also does the channel scaling. The whole pipeline advances together and holds
// while a result waits. Nothing is accepted while reset is high.
module rgb_hsl_240_converter_top (
  input wire logic clk,
  input wire logic rst,
  rhc_in_if.sink   req,
  rhc_out_if.source rsp
);
  import rhc_pkg::*;

  item_t chain [QW+1];
  logic  chain_vld [QW+1];
  logic  en;

  // Pipeline advances unless a finished result is held.
  assign en = !rsp.valid || rsp.ready;

  rhc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .req  (req),
    .item (chain[0]),
    .vld  (chain_vld[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    rhc_div_cell #(.BIT(QW-1-i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .din      (chain[i]),
      .din_vld  (chain_vld[i]),
      .dout     (chain[i+1]),
      .dout_vld (chain_vld[i+1])
    );
  end

  rhc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .din     (chain[QW]),
    .din_vld (chain_vld[QW]),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire
